/* sv/ab_boot_slot_selector_defines.svh */
// ----------------------------------------------------------------------------
// A/B boot slot selector assertion macros
// Concurrent assertion wrappers; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef AB_BOOT_SLOT_SELECTOR_DEFINES_SVH
`define AB_BOOT_SLOT_SELECTOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define AB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);
`define AB_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
		else $error(msg);
`else
`define AB_ASSERT(label, clk, rst_n, prop, msg)
`define AB_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

/* sv/absel_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// A/B boot slot selector package
// Event, slot, mode and error codes, transaction types and slot helpers.
// ----------------------------------------------------------------------------
package absel_pkg;

	localparam logic [1:0] MODE_DECIDE  = 2'd0;
	localparam logic [1:0] MODE_ARM     = 2'd1;
	localparam logic [1:0] MODE_CONFIRM = 2'd2;

	localparam logic [2:0] CMD_NONE    = 3'd0;
	localparam logic [2:0] CMD_DEFAULT = 3'd1;
	localparam logic [2:0] CMD_UPDATE  = 3'd2;
	localparam logic [2:0] CMD_STAY    = 3'd3;
	localparam logic [2:0] CMD_SLOT_A  = 3'd4;
	localparam logic [2:0] CMD_SLOT_B  = 3'd5;
	localparam logic [2:0] CMD_SAFE_A  = 3'd6;
	localparam logic [2:0] CMD_SAFE_B  = 3'd7;

	localparam logic [1:0] SLOT_NONE = 2'd0;
	localparam logic [1:0] SLOT_A    = 2'd1;
	localparam logic [1:0] SLOT_B    = 2'd2;

	localparam logic [1:0] BM_NORMAL = 2'd0;
	localparam logic [1:0] BM_SAFE   = 2'd1;
	localparam logic [1:0] BM_MAINT  = 2'd2;

	localparam logic [2:0] ERR_NONE         = 3'd0;
	localparam logic [2:0] ERR_INVALID      = 3'd1;
	localparam logic [2:0] ERR_NOT_BOOTABLE = 3'd2;
	localparam logic [2:0] ERR_NO_SLOT      = 3'd3;
	localparam logic [2:0] ERR_ROLLBACK     = 3'd4;

	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] command;
		logic [1:0] target_slot;
		logic       metadata_valid;
		logic       slot_a_bootable;
		logic       slot_b_bootable;
	} item_t;

	typedef struct packed {
		logic [1:0] boot_mode;
		logic [1:0] chosen_slot;
		logic [2:0] error_code;
		logic       meta_updated;
		logic       accepted;
		logic [1:0] active_slot_now;
	} result_t;

	function automatic logic can_boot(input logic [1:0] slot, input logic a_ok,
			input logic b_ok);
		can_boot = (slot == SLOT_A) ? a_ok : ((slot == SLOT_B) ? b_ok : 1'b0);
	endfunction

	function automatic logic [1:0] partner(input logic [1:0] slot);
		partner = (slot == SLOT_A) ? SLOT_B : ((slot == SLOT_B) ? SLOT_A : SLOT_NONE);
	endfunction

	// boot slot, active slot, the other slot, then A, then B
	function automatic logic [1:0] pick_fallback(input logic [1:0] bs,
			input logic [1:0] as, input logic a_ok, input logic b_ok);
		if (can_boot(bs, a_ok, b_ok))
			pick_fallback = bs;
		else if (can_boot(as, a_ok, b_ok))
			pick_fallback = as;
		else if (can_boot(partner(as), a_ok, b_ok))
			pick_fallback = partner(as);
		else if (a_ok)
			pick_fallback = SLOT_A;
		else if (b_ok)
			pick_fallback = SLOT_B;
		else
			pick_fallback = SLOT_NONE;
	endfunction

endpackage

/* sv/ab_boot_slot_selector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// A/B boot slot selector
// The input transaction is taken into an input register and its result is
// offered from a result register. Throughput: one transaction per cycle
// unless out_ready stalls the output; the state update is combinational.
// Reset: active and boot slot A, no trial, counters zero, both sides empty.
// ----------------------------------------------------------------------------
`include "ab_boot_slot_selector_defines.svh"

module ab_boot_slot_selector
	import absel_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [2:0] command,
	input  logic [1:0] target_slot,
	input  logic       metadata_valid,
	input  logic       slot_a_bootable,
	input  logic       slot_b_bootable,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] boot_mode,
	output logic [1:0] chosen_slot,
	output logic [2:0] error_code,
	output logic       meta_updated,
	output logic       accepted,
	output logic [1:0] active_slot_now
);

	logic                   valid_s1;
	item_t                  item_s1;
	logic                   adv_s1;
	logic                   out_valid_q;
	result_t                res_q;
	result_t                res_d;

	logic [1:0]             active_slot_q, active_slot_d;
	logic [1:0]             boot_slot_q, boot_slot_d;
	logic [1:0]             trial_sel_q, trial_sel_d;
	logic                   trial_on_q, trial_on_d;
	logic                   trial_attempted_q, trial_attempted_d;
	logic [2:0]             last_error_q, last_error_d;
	logic [COUNT_WIDTH-1:0] failed_cnt_q [2];
	logic [COUNT_WIDTH-1:0] confirmed_cnt_q [2];
	logic                   fail_inc, conf_inc, cnt_idx;
	logic [1:0]             fb_slot;
	logic                   a_ok, b_ok;

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{mode, command, target_slot, metadata_valid,
				slot_a_bootable, slot_b_bootable};
		end
	end

	assign a_ok    = item_s1.slot_a_bootable;
	assign b_ok    = item_s1.slot_b_bootable;
	assign cnt_idx = ~trial_sel_q[0];

	always_comb begin
		active_slot_d     = active_slot_q;
		boot_slot_d       = boot_slot_q;
		trial_sel_d       = trial_sel_q;
		trial_on_d        = trial_on_q;
		trial_attempted_d = trial_attempted_q;
		last_error_d      = last_error_q;
		fail_inc          = 1'b0;
		conf_inc          = 1'b0;
		fb_slot           = SLOT_NONE;
		res_d             = '0;
		case (item_s1.mode)
			MODE_DECIDE: begin
				if (!item_s1.metadata_valid) begin
					res_d.boot_mode  = BM_MAINT;
					res_d.error_code = ERR_INVALID;
				end else begin
					case (item_s1.command) inside
						CMD_UPDATE, CMD_STAY: begin
							res_d.boot_mode = BM_MAINT;
						end
						[CMD_SLOT_A:CMD_SAFE_B]: begin
							fb_slot = item_s1.command[0] ? SLOT_B : SLOT_A;
							if (can_boot(fb_slot, a_ok, b_ok)) begin
								res_d.boot_mode   = item_s1.command[1] ? BM_SAFE : BM_NORMAL;
								res_d.chosen_slot = fb_slot;
							end else begin
								res_d.boot_mode  = BM_MAINT;
								res_d.error_code = ERR_NOT_BOOTABLE;
							end
						end
						default: begin
							if (trial_on_q && trial_sel_q != SLOT_NONE) begin
								res_d.meta_updated = 1'b1;
								if (!can_boot(trial_sel_q, a_ok, b_ok)) begin
									trial_on_d        = 1'b0;
									trial_attempted_d = 1'b0;
									trial_sel_d       = SLOT_NONE;
									last_error_d      = ERR_NOT_BOOTABLE;
									res_d.boot_mode   = BM_MAINT;
									res_d.error_code  = ERR_NOT_BOOTABLE;
								end else if (!trial_attempted_q) begin
									trial_attempted_d = 1'b1;
									boot_slot_d       = trial_sel_q;
									res_d.chosen_slot = trial_sel_q;
								end else begin
									// rollback of an unconfirmed trial
									fail_inc          = 1'b1;
									trial_on_d        = 1'b0;
									trial_attempted_d = 1'b0;
									trial_sel_d       = SLOT_NONE;
									boot_slot_d       = active_slot_q;
									last_error_d      = ERR_ROLLBACK;
									if (can_boot(active_slot_q, a_ok, b_ok)) begin
										res_d.chosen_slot = active_slot_q;
										res_d.error_code  = ERR_ROLLBACK;
									end else begin
										fb_slot = pick_fallback(active_slot_q, active_slot_q,
											a_ok, b_ok);
										if (fb_slot != SLOT_NONE) begin
											boot_slot_d       = fb_slot;
											res_d.chosen_slot = fb_slot;
											res_d.error_code  = ERR_ROLLBACK;
										end else begin
											res_d.boot_mode  = BM_MAINT;
											res_d.error_code = ERR_NO_SLOT;
										end
									end
								end
							end else begin
								fb_slot = pick_fallback(boot_slot_q, active_slot_q, a_ok, b_ok);
								if (fb_slot == SLOT_NONE) begin
									res_d.boot_mode  = BM_MAINT;
									res_d.error_code = ERR_NO_SLOT;
								end else begin
									boot_slot_d       = fb_slot;
									res_d.chosen_slot = fb_slot;
								end
							end
						end
					endcase
				end
			end
			MODE_ARM: begin
				if (can_boot(item_s1.target_slot, a_ok, b_ok)) begin
					trial_sel_d       = item_s1.target_slot;
					trial_on_d        = 1'b1;
					trial_attempted_d = 1'b0;
					boot_slot_d       = item_s1.target_slot;
					res_d.accepted    = 1'b1;
				end
			end
			MODE_CONFIRM: begin
				if (trial_on_q && trial_sel_q != SLOT_NONE &&
						can_boot(trial_sel_q, a_ok, b_ok)) begin
					active_slot_d     = trial_sel_q;
					boot_slot_d       = trial_sel_q;
					conf_inc          = 1'b1;
					trial_sel_d       = SLOT_NONE;
					trial_on_d        = 1'b0;
					trial_attempted_d = 1'b0;
					last_error_d      = ERR_NONE;
					res_d.accepted    = 1'b1;
				end
			end
			default: begin
				res_d = '0;
			end
		endcase
		res_d.active_slot_now = active_slot_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_slot_q     <= SLOT_A;
			boot_slot_q       <= SLOT_A;
			trial_sel_q       <= SLOT_NONE;
			trial_on_q        <= 1'b0;
			trial_attempted_q <= 1'b0;
			last_error_q      <= ERR_NONE;
			failed_cnt_q      <= '{default: '0};
			confirmed_cnt_q   <= '{default: '0};
			out_valid_q       <= 1'b0;
		end else begin
			if (adv_s1) begin
				active_slot_q     <= active_slot_d;
				boot_slot_q       <= boot_slot_d;
				trial_sel_q       <= trial_sel_d;
				trial_on_q        <= trial_on_d;
				trial_attempted_q <= trial_attempted_d;
				last_error_q      <= last_error_d;
				if (fail_inc && failed_cnt_q[cnt_idx] != '1) begin
					failed_cnt_q[cnt_idx] <= failed_cnt_q[cnt_idx] + 1'b1;
				end
				if (conf_inc && confirmed_cnt_q[cnt_idx] != '1) begin
					confirmed_cnt_q[cnt_idx] <= confirmed_cnt_q[cnt_idx] + 1'b1;
				end
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign boot_mode        = res_q.boot_mode;
	assign chosen_slot      = res_q.chosen_slot;
	assign error_code       = res_q.error_code;
	assign meta_updated     = res_q.meta_updated;
	assign accepted         = res_q.accepted;
	assign active_slot_now  = res_q.active_slot_now;

	`AB_ASSERT(a_active_slot_real, clk, arst_n,
		active_slot_q == SLOT_A || active_slot_q == SLOT_B, "active slot is not A or B")
	`AB_ASSERT(a_idle_trial_clear, clk, arst_n,
		!trial_on_q |-> (trial_sel_q == SLOT_NONE && !trial_attempted_q),
		"trial state left behind without an armed trial")
	`AB_ASSERT(a_accept_result_quiet, clk, arst_n,
		(out_valid_q && res_q.accepted) |-> (res_q.boot_mode == BM_NORMAL &&
		res_q.chosen_slot == SLOT_NONE && res_q.error_code == ERR_NONE &&
		!res_q.meta_updated), "arm or confirm result carries decision fields")
	`AB_ASSERT(a_confirm_clears_error, clk, arst_n,
		(adv_s1 && conf_inc) |=> (last_error_q == ERR_NONE && !trial_on_q),
		"confirm did not clear the error and the trial")
	`AB_ASSERT_NEVER(a_maint_without_slot, clk, arst_n,
		out_valid_q && res_q.boot_mode == BM_MAINT && res_q.chosen_slot != SLOT_NONE,
		"maintenance boot names a slot")
	`AB_ASSERT(a_advance_loads_result, clk, arst_n,
		adv_s1 |=> out_valid_q, "result register not loaded on advance")

endmodule
